FILE: rtl/tcwe_pkg.sv
// Shared types and constants for the TCP congestion window engine.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package tcwe_pkg;

    // Payload widths.
    localparam int WordW    = 32;
    localparam int SegW     = 16;
    localparam int AckW     = 16;
    localparam int KindW    = 2;

    // Configuration port.
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;

    // Register index of the segment size (taken from paddr[2]).
    localparam logic RegSegmentSize = 1'b0;

    // Segment size after reset, in bytes.
    localparam logic [SegW-1:0] SegReset = 16'd536;

    // Item kinds; the fourth code is unused and leaves the state alone.
    typedef enum logic [KindW-1:0] {
        KIND_ACK  = 2'd0,
        KIND_LOSS = 2'd1,
        KIND_LOAD = 2'd2
    } t_kind;

endpackage

`default_nettype wire

FILE: rtl/tcwe_if.sv
// Valid/ready channel interfaces for item input and result output.
// Depends on tcwe_pkg for payload widths.
`default_nettype none

interface tcwe_in_if;
    import tcwe_pkg::*;

    logic               valid;
    logic               ready;
    logic [KindW-1:0]   kind;
    logic [AckW-1:0]    segments_acked;
    logic [WordW-1:0]   bytes_in_flight;
    logic               in_recovery;
    logic [WordW-1:0]   load_window;
    logic [WordW-1:0]   load_threshold;

    modport source (
        output valid, kind, segments_acked, bytes_in_flight, in_recovery,
               load_window, load_threshold,
        input  ready
    );
    modport sink (
        input  valid, kind, segments_acked, bytes_in_flight, in_recovery,
               load_window, load_threshold,
        output ready
    );
endinterface

interface tcwe_out_if;
    import tcwe_pkg::*;

    logic               valid;
    logic               ready;
    logic [WordW-1:0]   window_bytes;
    logic [WordW-1:0]   threshold_bytes;
    logic [WordW-1:0]   loss_threshold;

    modport source (
        output valid, window_bytes, threshold_bytes, loss_threshold,
        input  ready
    );
    modport sink (
        input  valid, window_bytes, threshold_bytes, loss_threshold,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tcp_congestion_window_engine_unit.sv
// TCP congestion window engine: window, slow-start threshold and remembered size.
// Loss, load and ack items that need no division show their registered result in the
// cycle after acceptance; an ack that needs the radix-2 divider runs setup, 32 divider
// steps and a finish state that waits for output room. One item is taken at a time.
// Reset (synchronous, active low) clears window, threshold and remembered size,
// sets the segment size to 536 and empties the output register. Uses tcwe_pkg, tcwe_if.
`default_nettype none

module tcp_congestion_window_engine_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    tcwe_in_if.sink                          in_ch,
    tcwe_out_if.source                       out_ch,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [tcwe_pkg::ApbAddrW-1:0]    paddr,
    input  wire  [tcwe_pkg::ApbDataW-1:0]    pwdata,
    output logic [tcwe_pkg::ApbDataW-1:0]    prdata,
    output logic                             pready
);
    import tcwe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    // Saturating 32-bit add.
    function automatic logic [WordW-1:0] sat_add(input logic [WordW-1:0] a,
                                                 input logic [WordW-1:0] b);
        logic [WordW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WordW] ? '1 : s[WordW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [SegW-1:0]    r_seg, n_seg;
    logic [WordW-1:0]   r_window, n_window;
    logic [WordW-1:0]   r_thresh, n_thresh;
    logic [WordW-1:0]   r_remem, n_remem;
    logic [WordW-1:0]   r_rem, n_rem;
    logic [WordW-1:0]   r_quo, n_quo;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [WordW-1:0]   r_out_window, n_out_window;
    logic [WordW-1:0]   r_out_thresh, n_out_thresh;
    logic [WordW-1:0]   r_out_loss, n_out_loss;

    logic               in_fire;
    logic               out_free;
    logic               cfg_write;
    logic               emit;
    logic [WordW-1:0]   emit_loss;

    logic               slow;
    logic               grow_one;
    logic               more_acked;
    logic [WordW-1:0]   ack_window;
    logic               need_div;
    logic [WordW-1:0]   seg_sq;

    logic [WordW-1:0]   loss_floor;
    logic [WordW-1:0]   loss_half;
    logic [WordW-1:0]   loss_max;
    logic [WordW-1:0]   loss_value;

    logic [WordW+1:0]   trial;
    logic [WordW-1:0]   grow_term;

    // Handshakes.
    assign out_free  = !r_out_valid || out_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE) && out_free;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegSegmentSize);

    assign out_ch.valid           = r_out_valid;
    assign out_ch.window_bytes    = r_out_window;
    assign out_ch.threshold_bytes = r_out_thresh;
    assign out_ch.loss_threshold  = r_out_loss;

    assign pready = 1'b1;
    assign prdata = {{(ApbDataW-SegW){1'b0}}, r_seg};

    // Ack front end: slow-start step and the decision to run the divider.
    assign slow       = r_window < r_thresh;
    assign grow_one   = slow && (in_ch.segments_acked != '0);
    assign more_acked = slow ? (in_ch.segments_acked > AckW'(1))
                             : (in_ch.segments_acked != '0);
    assign ack_window = grow_one ? sat_add(r_window, {{(WordW-SegW){1'b0}}, r_seg}) : r_window;
    assign need_div   = (ack_window >= r_thresh) && more_acked;
    assign seg_sq     = {{(WordW-SegW){1'b0}}, r_seg} * {{(WordW-SegW){1'b0}}, r_seg};

    // Loss threshold: max of twice the segment, half the flight and the remembered size.
    assign loss_floor = {{(WordW-SegW-1){1'b0}}, r_seg, 1'b0};
    assign loss_half  = {1'b0, in_ch.bytes_in_flight[WordW-1:1]};
    assign loss_max   = (loss_floor > loss_half) ? loss_floor : loss_half;
    assign loss_value = (r_remem > loss_max) ? r_remem : loss_max;

    // Restoring divider step and the growth term, raised to at least one.
    assign trial     = {1'b0, r_rem, r_quo[WordW-1]} - {2'b00, r_window};
    assign grow_term = (r_quo == '0) ? WordW'(1) : r_quo;

    // Sequencer and datapath next state.
    always_comb begin
        n_state      = r_state;
        n_seg        = r_seg;
        n_window     = r_window;
        n_thresh     = r_thresh;
        n_remem      = r_remem;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !out_ch.ready;
        n_out_window = r_out_window;
        n_out_thresh = r_out_thresh;
        n_out_loss   = r_out_loss;
        emit         = 1'b0;
        emit_loss    = '0;

        if (cfg_write) begin
            n_seg = pwdata[SegW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_kind'(in_ch.kind))
                        KIND_ACK: begin
                            n_window = ack_window;
                            if (!need_div) begin
                                emit = 1'b1;
                            end else if (ack_window == '0) begin
                                // Zero divisor: the quotient is the maximum.
                                n_window = '1;
                                emit     = 1'b1;
                            end else begin
                                n_rem   = '0;
                                n_quo   = seg_sq;
                                n_cnt   = 5'd31;
                                n_state = S_DIV;
                            end
                        end
                        KIND_LOSS: begin
                            n_thresh  = loss_value;
                            emit_loss = loss_value;
                            emit      = 1'b1;
                            if (in_ch.in_recovery && (in_ch.bytes_in_flight != '0)) begin
                                n_remem = in_ch.bytes_in_flight;
                            end
                        end
                        KIND_LOAD: begin
                            n_window = in_ch.load_window;
                            n_thresh = in_ch.load_threshold;
                            emit     = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (!trial[WordW+1]) begin
                    n_rem = trial[WordW-1:0];
                end else begin
                    n_rem = {r_rem[WordW-2:0], r_quo[WordW-1]};
                end
                n_quo = {r_quo[WordW-2:0], !trial[WordW+1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_window = sat_add(r_window, grow_term);
                    emit     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the output register with the state after this item.
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_window = n_window;
            n_out_thresh = n_thresh;
            n_out_loss   = emit_loss;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg       <= SegReset;
            r_window    <= '0;
            r_thresh    <= '0;
            r_remem     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seg       <= n_seg;
            r_window    <= n_window;
            r_thresh    <= n_thresh;
            r_remem     <= n_remem;
            r_out_valid <= n_out_valid;
        end
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_out_window <= n_out_window;
        r_out_thresh <= n_out_thresh;
        r_out_loss   <= n_out_loss;
    end

    // The divider loop never disturbs the architectural window and threshold.
    a_div_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> $stable(r_window) && $stable(r_thresh))
        else $error("window or threshold changed during division");

    // A new transaction is only taken when its result has room.
    a_accept_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> out_free)
        else $error("input accepted while output register is blocked");

    // The last divider step always hands over to the finish state.
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == '0 |=> r_state == S_FIN)
        else $error("divider did not finish after its last step");

endmodule

`default_nettype wire
